@@ hdl/tlsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Thick line stroke raster package
// Shared types and constants: opcodes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package tlsr_pkg;

   // Request opcodes.
   typedef enum logic [0:0] {
      OP_DRAW = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_RASTER_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_RASTER_HEIGHT = 2'd1;

   // Register reset value and full ink level.
   localparam logic [9:0] RASTER_RESET = 10'd512;
   localparam logic [7:0] INK_FULL     = 8'd255;

   // Bit positions of the square root search and of the quotient.
   localparam int SQRT_TOP_BIT = 12;
   localparam int QUOT_TOP_BIT = 12;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_READ_WAIT,
      ST_SQ_DX,
      ST_SQ_DY,
      ST_SQRT,
      ST_SQFIX,
      ST_MULX,
      ST_MULY,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_STAMP,
      ST_NEXT,
      ST_DONE
   } state_type;

endpackage

@@ hdl/tlsr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module tlsr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Storage array with a registered read port.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/thick_line_stroke_raster.sv @@
// ----------------------------------------------------------------------------
// Thick line stroke raster
// One-bit stroke map; draw items stamp square brushes along a segment and
// read items return the mark and ink level of one pixel.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole map to zero, one pixel per cycle,
// and takes no request until the sweep is done. It handles one request at a
// time. A read passes through the read, read wait and done states before its
// result is registered. A draw with a zero brush or an empty raster goes
// straight to the done state. Any other draw runs on one shared multiplier and
// a shift-subtract divider: it finds the step count (a 13-bit square root
// search), forms the start products, then for each of the steps+1 positions
// runs the two rounded divisions, stamps the brush_size*brush_size square
// (one pixel write per cycle through the single map port) and moves on,
// where steps is twice the rounded-up length of the segment, or one if that
// is zero. A finished result sits in an output register, so the next
// request may transfer while it waits.
// ----------------------------------------------------------------------------
module thick_line_stroke_raster #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                     clock,
   input  logic                     reset,
   // Configuration port.
   input  logic                     csr_write_en,
   input  logic [1:0]               csr_index,
   input  logic [9:0]               csr_wdata,
   // Request channel.
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tlsr_pkg::opcode_type     req_opcode,
   input  logic signed [11:0]       req_start_x,
   input  logic signed [11:0]       req_start_y,
   input  logic signed [11:0]       req_end_x,
   input  logic signed [11:0]       req_end_y,
   input  logic [4:0]               req_brush_size,
   // Response channel.
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_stroke_bit,
   output logic [7:0]               rsp_ink_level
);

   import tlsr_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   // Registers.
   state_type          state_ff, state_in;
   logic [9:0]         wr_w_ff, wr_h_ff;
   logic [AW-1:0]      clr_ff, clr_in;
   logic signed [11:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [12:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [4:0]         brush_ff, brush_in;
   logic [25:0]        sq_ff, sq_in;
   logic [13:0]        r_ff, r_in;
   logic [3:0]         k_ff, k_in;
   logic [14:0]        steps_ff, steps_in, s_ff, s_in;
   logic signed [28:0] numx_ff, numx_in, numy_ff, numy_in;
   logic               div_sel_ff, div_sel_in, div_neg_ff, div_neg_in;
   logic [29:0]        rem_ff, rem_in;
   logic [12:0]        q_ff, q_in;
   logic signed [13:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [4:0]         i_ff, i_in, j_ff, j_in;
   logic               hit_ff, hit_in, bit_ff, bit_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_bit_ff, rsp_bit_in;

   // Combinational signals.
   logic [9:0]         eff_w, eff_h;
   logic signed [14:0] mul_a, mul_b;
   logic signed [29:0] product;
   logic [13:0]        trial;
   logic [13:0]        r_fix;
   logic signed [28:0] num_sel;
   logic [28:0]        num_mag;
   logic [29:0]        div_shift;
   logic signed [13:0] px, py;
   logic               px_ok, py_ok, rd_ok;
   logic [29:0]        addr_full;
   logic               ram_we, ram_wdata, ram_rdata;
   logic [AW-1:0]      ram_addr;
   logic               rsp_free;

   // Effective raster size, clamped to the map.
   always_comb begin
      eff_w = ({22'd0, wr_w_ff} > MAX_WIDTH)  ? 10'(MAX_WIDTH)  : wr_w_ff;
      eff_h = ({22'd0, wr_h_ff} > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : wr_h_ff;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_w_ff <= RASTER_RESET;
         wr_h_ff <= RASTER_RESET;
      end else if (csr_write_en) begin
         if (csr_index == CSR_RASTER_WIDTH) begin
            wr_w_ff <= csr_wdata;
         end else if (csr_index == CSR_RASTER_HEIGHT) begin
            wr_h_ff <= csr_wdata;
         end
      end
   end

   // Stamp pixel position and clipping.
   always_comb begin
      px    = cx_ff + 14'(i_ff);
      py    = cy_ff + 14'(j_ff);
      px_ok = !px[13] && (px[12:0] < 13'(eff_w));
      py_ok = !py[13] && (py[12:0] < 13'(eff_h));
      rd_ok = !sx_ff[11] && !sy_ff[11] && (sx_ff[10:0] < 11'(eff_w))
              && (sy_ff[10:0] < 11'(eff_h));
   end

   // Shared multiplier operand selection.
   always_comb begin
      trial = r_ff | (14'd1 << k_ff);
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ_DX: begin
            mul_a = 15'(dx_ff);
            mul_b = 15'(dx_ff);
         end
         ST_SQ_DY: begin
            mul_a = 15'(dy_ff);
            mul_b = 15'(dy_ff);
         end
         ST_SQRT: begin
            mul_a = $signed({1'b0, trial});
            mul_b = $signed({1'b0, trial});
         end
         ST_SQFIX: begin
            mul_a = $signed({1'b0, r_ff});
            mul_b = $signed({1'b0, r_ff});
         end
         ST_MULX: begin
            mul_a = 15'(sx_ff);
            mul_b = $signed(steps_ff);
         end
         ST_MULY: begin
            mul_a = 15'(sy_ff);
            mul_b = $signed(steps_ff);
         end
         ST_STAMP: begin
            mul_a = 15'(py);
            mul_b = $signed({5'd0, eff_w});
         end
         ST_READ: begin
            mul_a = 15'(sy_ff);
            mul_b = $signed({5'd0, eff_w});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      product = mul_a * mul_b;
   end

   // Divider operand preparation, square root rounding fix and response free flag.
   always_comb begin
      num_sel   = div_sel_ff ? numy_ff : numx_ff;
      num_mag   = num_sel[28] ? 29'(-num_sel) : 29'(num_sel);
      div_shift = 30'({steps_ff, 1'b0}) << k_ff;
      r_fix     = r_ff + 14'((product < $signed({4'd0, sq_ff})) ? 1 : 0);
      rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Sequencer: next state, datapath updates and map port.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      brush_in     = brush_ff;
      sq_in        = sq_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      steps_in     = steps_ff;
      s_in         = s_ff;
      numx_in      = numx_ff;
      numy_in      = numy_ff;
      div_sel_in   = div_sel_ff;
      div_neg_in   = div_neg_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      hit_in       = hit_ff;
      bit_in       = bit_ff;
      rsp_bit_in   = rsp_bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;
      ram_wdata    = 1'b0;
      addr_full    = 30'(product) + 30'(px);
      ram_addr     = clr_ff;
      req_stall    = 1'b1;

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               sx_in    = req_start_x;
               sy_in    = req_start_y;
               dx_in    = 13'(req_end_x) - 13'(req_start_x);
               dy_in    = 13'(req_end_y) - 13'(req_start_y);
               brush_in = req_brush_size;
               bit_in   = 1'b0;
               if (req_opcode == OP_READ) begin
                  state_in = ST_READ;
               end else if (req_brush_size == 5'd0 || eff_w == 10'd0
                            || eff_h == 10'd0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SQ_DX;
               end
            end
         end
         ST_READ: begin
            addr_full = 30'(product) + 30'(sx_ff);
            ram_addr  = addr_full[AW-1:0];
            hit_in    = rd_ok;
            state_in  = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            bit_in   = hit_ff && ram_rdata;
            state_in = ST_DONE;
         end
         ST_SQ_DX: begin
            sq_in    = 26'(product);
            state_in = ST_SQ_DY;
         end
         ST_SQ_DY: begin
            sq_in    = sq_ff + 26'(product);
            r_in     = '0;
            k_in     = 4'(SQRT_TOP_BIT);
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            // Largest r with r*r not above the squared length, one bit a cycle.
            if (product <= $signed({4'd0, sq_ff})) begin
               r_in = trial;
            end
            k_in = k_ff - 1'b1;
            if (k_ff == 4'd0) begin
               state_in = ST_SQFIX;
            end
         end
         ST_SQFIX: begin
            // Round up to the ceiling and double; at least one step.
            steps_in = (r_fix == 14'd0) ? 15'd1 : {r_fix, 1'b0};
            state_in = ST_MULX;
         end
         ST_MULX: begin
            numx_in  = 29'(product);
            state_in = ST_MULY;
         end
         ST_MULY: begin
            numy_in    = 29'(product);
            s_in       = '0;
            div_sel_in = 1'b0;
            state_in   = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            // Rounded division: (2|num| + steps) / (2 steps), sign reapplied.
            div_neg_in = num_sel[28];
            rem_in     = 30'({num_mag, 1'b0}) + 30'(steps_ff);
            q_in       = '0;
            k_in       = 4'(QUOT_TOP_BIT);
            state_in   = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (rem_ff >= div_shift) begin
               rem_in   = rem_ff - div_shift;
               q_in     = q_ff | (13'd1 << k_ff);
            end
            k_in = k_ff - 1'b1;
            if (k_ff == 4'd0) begin
               if (!div_sel_ff) begin
                  cx_in      = div_neg_ff ? -$signed({1'b0, q_in}) : $signed({1'b0, q_in});
                  div_sel_in = 1'b1;
                  state_in   = ST_DIV_LOAD;
               end else begin
                  cy_in    = div_neg_ff ? -$signed({1'b0, q_in}) : $signed({1'b0, q_in});
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_STAMP;
               end
            end
         end
         ST_STAMP: begin
            // One brush pixel per cycle, clipped to the active raster.
            ram_addr  = addr_full[AW-1:0];
            ram_we    = px_ok && py_ok;
            ram_wdata = 1'b1;
            if (i_ff == brush_ff - 1'b1) begin
               i_in = '0;
               j_in = j_ff + 1'b1;
               if (j_ff == brush_ff - 1'b1) begin
                  state_in = ST_NEXT;
               end
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_NEXT: begin
            if (s_ff == steps_ff) begin
               state_in = ST_DONE;
            end else begin
               s_in       = s_ff + 1'b1;
               numx_in    = numx_ff + 29'(dx_ff);
               numy_in    = numy_ff + 29'(dy_ff);
               div_sel_in = 1'b0;
               state_in   = ST_DIV_LOAD;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = bit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      brush_ff   <= brush_in;
      sq_ff      <= sq_in;
      r_ff       <= r_in;
      k_ff       <= k_in;
      steps_ff   <= steps_in;
      s_ff       <= s_in;
      numx_ff    <= numx_in;
      numy_ff    <= numy_in;
      div_sel_ff <= div_sel_in;
      div_neg_ff <= div_neg_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      hit_ff     <= hit_in;
      bit_ff     <= bit_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   // Stroke map.
   tlsr_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_map (
      .clock    (clock),
      .write_en (ram_we),
      .addr     (ram_addr),
      .wdata    (ram_wdata),
      .rdata    (ram_rdata)
   );

   // Response outputs.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_stroke_bit = rsp_bit_ff;
   assign rsp_ink_level  = rsp_bit_ff ? INK_FULL : 8'd0;

   // The map is only written by the clearing sweep or by the stamp.
   a_map_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_STAMP))
      else $error("map written outside clear or stamp");

   // The clearing sweep writes zeros at every cycle.
   a_clear_writes_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (ram_we && !ram_wdata))
      else $error("clearing sweep did not write zero");

   // Stamp counters stay inside the brush square.
   a_stamp_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STAMP) |-> (i_ff < brush_ff && j_ff < brush_ff))
      else $error("stamp counter beyond brush size");

   // A response is loaded only from the done state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !$past(reset)) ##1 rsp_valid_ff |-> $past(state_ff == ST_DONE))
      else $error("response raised outside done state");

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Thick line stroke raster testbench
// Drives draw and read requests through the valid/stall channels while the
// response side stalls at random. A scoreboard keeps its own copy of the
// stroke map and the raster size, predicts each response and checks it
// field by field. The raster size registers are changed between phases.
// ----------------------------------------------------------------------------
module testbench;
   import tlsr_pkg::*;

   localparam int MAP_W = 512;
   localparam int MAP_H = 512;

   typedef struct {
      opcode_type         op;
      logic signed [11:0] sx;
      logic signed [11:0] sy;
      logic signed [11:0] ex;
      logic signed [11:0] ey;
      logic [4:0]         brush;
   } stroke_req_type;

   typedef struct {
      logic       mark;
      logic [7:0] ink;
   } pixel_rsp_type;

   // Scoreboard: mirrors the stroke map and predicts every response.
   class raster_scoreboard;
      bit            map_bits [MAP_W*MAP_H];
      logic [9:0]    width_reg;
      logic [9:0]    height_reg;
      pixel_rsp_type pending [$];
      int            errors;
      int            checked;
      int            draws;
      int            reads;
      int            marked_reads;

      function new();
         width_reg  = RASTER_RESET;
         height_reg = RASTER_RESET;
      endfunction

      function void write_reg(logic [1:0] idx, logic [9:0] data);
         if (idx == CSR_RASTER_WIDTH) width_reg = data;
         else if (idx == CSR_RASTER_HEIGHT) height_reg = data;
      endfunction

      function int eff_w();
         return (width_reg > MAP_W) ? MAP_W : int'(width_reg);
      endfunction

      function int eff_h();
         return (height_reg > MAP_H) ? MAP_H : int'(height_reg);
      endfunction

      // Smallest r with r*r >= n.
      function longint root_up(longint n);
         longint lo, hi, mid;
         lo = 0;
         hi = 65536;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (mid * mid >= n) hi = mid;
            else lo = mid + 1;
         end
         return lo;
      endfunction

      // Division rounded half away from zero; den is positive.
      function longint round_div(longint num, longint den);
         if (num >= 0) return (2 * num + den) / (2 * den);
         return -((2 * (-num) + den) / (2 * den));
      endfunction

      function void stamp_stroke(stroke_req_type r);
         longint x0, y0, dx, dy, steps, cx, cy, px, py;
         int w, h;
         x0 = r.sx;
         y0 = r.sy;
         dx = longint'(r.ex) - x0;
         dy = longint'(r.ey) - y0;
         w = eff_w();
         h = eff_h();
         steps = 2 * root_up(dx * dx + dy * dy);
         if (steps < 1) steps = 1;
         if (r.brush == 0 || w == 0 || h == 0) return;
         for (longint s = 0; s <= steps; s++) begin
            cx = round_div(x0 * steps + dx * s, steps);
            cy = round_div(y0 * steps + dy * s, steps);
            for (int j = 0; j < r.brush; j++) begin
               py = cy + j;
               if (py < 0 || py >= h) continue;
               for (int i = 0; i < r.brush; i++) begin
                  px = cx + i;
                  if (px < 0 || px >= w) continue;
                  map_bits[py * w + px] = 1'b1;
               end
            end
         end
      endfunction

      // Note an accepted request and queue the response it must produce.
      function void note_request(stroke_req_type r);
         pixel_rsp_type p;
         int w, h;
         p.mark = 1'b0;
         if (r.op == OP_DRAW) begin
            draws++;
            stamp_stroke(r);
         end else begin
            reads++;
            w = eff_w();
            h = eff_h();
            if (r.sx >= 0 && r.sy >= 0 && r.sx < w && r.sy < h)
               p.mark = map_bits[int'(r.sy) * w + int'(r.sx)];
            if (p.mark) marked_reads++;
         end
         p.ink = p.mark ? INK_FULL : 8'd0;
         pending.push_back(p);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      // Compare one accepted response with the oldest prediction.
      task check_response(logic mark, logic [7:0] ink);
         pixel_rsp_type p;
         checked++;
         if (pending.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         p = pending.pop_front();
         if (mark !== p.mark)
            report($sformatf("stroke_bit %b, predicted %b", mark, p.mark));
         if (ink !== p.ink)
            report($sformatf("ink_level %0d, predicted %0d", ink, p.ink));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [9:0]         csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   opcode_type         req_opcode = OP_DRAW;
   logic signed [11:0] req_start_x = '0;
   logic signed [11:0] req_start_y = '0;
   logic signed [11:0] req_end_x = '0;
   logic signed [11:0] req_end_y = '0;
   logic [4:0]         req_brush_size = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_stroke_bit;
   logic [7:0]         rsp_ink_level;

   raster_scoreboard sb = new();
   bit stall_quiet = 1'b0;

   thick_line_stroke_raster u_dut (.*);

   always #6 clock = ~clock;

   // Random length of an idle stretch: mostly short, sometimes long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Response stall pattern, with quiet stretches where it never stalls.
   always @(posedge clock) begin
      if (stall_quiet || reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < 30);
   end

   always @(posedge clock) begin
      if (!reset && $urandom_range(0, 299) == 0) stall_quiet <= ~stall_quiet;
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_stroke_bit, rsp_ink_level);
   end

   // Send one request and wait for its transfer, then idle for a random stretch that may be empty.
   task send_request(stroke_req_type r);
      int g;
      req_opcode     <= r.op;
      req_start_x    <= r.sx;
      req_start_y    <= r.sy;
      req_end_x      <= r.ex;
      req_end_y      <= r.ey;
      req_brush_size <= r.brush;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Let the block drain, then write one register.
   task write_csr(logic [1:0] idx, logic [9:0] data);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic stroke_req_type make_req(opcode_type op, int sx, int sy, int ex,
                                               int ey, int brush);
      stroke_req_type r;
      r.op    = op;
      r.sx    = 12'(sx);
      r.sy    = 12'(sy);
      r.ex    = 12'(ex);
      r.ey    = 12'(ey);
      r.brush = 5'(brush);
      return r;
   endfunction

   function automatic int clamp12(int v);
      if (v > 2047) return 2047;
      if (v < -2048) return -2048;
      return v;
   endfunction

   // Coordinate mostly below the given limit, sometimes anywhere.
   function automatic int pick_coord(int lim);
      if (lim > 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, lim - 1);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 2047 : -2048;
      return $signed(12'($urandom));
   endfunction

   // Random request: short strokes, small brushes and many reads.
   function automatic stroke_req_type random_req();
      int sx, sy, span, brush, r;
      sx = pick_coord(sb.eff_w() + 4);
      sy = pick_coord(sb.eff_h() + 4);
      r = $urandom_range(0, 99);
      if (r < 70) brush = $urandom_range(0, 5);
      else if (r < 95) brush = $urandom_range(6, 12);
      else brush = $urandom_range(13, 31);
      span = (brush > 12) ? 2 : (($urandom_range(0, 9) == 0) ? 40 : 12);
      return make_req($urandom_range(0, 1) ? OP_READ : OP_DRAW, sx, sy,
                      clamp12(sx + $urandom_range(0, 2 * span) - span),
                      clamp12(sy + $urandom_range(0, 2 * span) - span), brush);
   endfunction

   int width_list [6]  = '{512, 1023, 37, 1, 0, 300};
   int height_list [6] = '{512, 1023, 300, 1, 5, 512};

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes, both operations and the corner cases.
      send_request(make_req(OP_READ, -2048, -2048, 2047, 2047, 31));
      send_request(make_req(OP_DRAW, 10, 10, 40, 20, 0));
      send_request(make_req(OP_READ, 10, 10, 0, 0, 0));
      send_request(make_req(OP_DRAW, -2048, -2048, 2047, 2047, 1));
      send_request(make_req(OP_READ, 100, 100, 0, 0, 0));
      send_request(make_req(OP_READ, 101, 100, 0, 0, 0));
      send_request(make_req(OP_DRAW, 500, 500, 500, 500, 31));
      send_request(make_req(OP_READ, 511, 511, 0, 0, 0));
      send_request(make_req(OP_READ, 512, 511, 0, 0, 0));
      send_request(make_req(OP_READ, 2047, 2047, 0, 0, 0));
      send_request(make_req(OP_DRAW, 2047, 2047, 2040, -5, 3));
      send_request(make_req(OP_DRAW, -3, -3, 3, 5, 4));
      send_request(make_req(OP_READ, 0, 0, 0, 0, 0));
      send_request(make_req(OP_READ, 3, 5, 0, 0, 0));
      send_request(make_req(OP_READ, -1, 0, 0, 0, 0));
      send_request(make_req(OP_DRAW, 30, 40, 33, 40, 2));
      send_request(make_req(OP_READ, 31, 41, 0, 0, 0));
      // An unknown register index must be ignored.
      write_csr(2'd3, 10'd7);
      send_request(make_req(OP_READ, 31, 41, 0, 0, 0));

      // Random phases, each under a new raster size. The map is kept across
      // resizes, so reads then see old marks through the new pitch.
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_RASTER_WIDTH, 10'(width_list[ph]));
         write_csr(CSR_RASTER_HEIGHT, 10'(height_list[ph]));
         repeat (95) send_request(random_req());
      end

      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Covered %0d draws and %0d reads (%0d on marked pixels), %0d responses,",
               sb.draws, sb.reads, sb.marked_reads, sb.checked);
      $display("across six raster sizes including empty and oversized ones.");
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog for a hung block.
   initial begin
      #(12 * 60_000_000);
      $display("timeout with %0d responses outstanding", sb.pending.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
